FILE: design/assert_macros.svh
// Assertion helpers for the owner map block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AMR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define AMR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/amr_pkg.sv
package amr_pkg;
  localparam int GridN = 64;
  localparam int CoordBits = 6;
  localparam int AddrBits = 12;
  localparam int ValueBits = 16;
  localparam int OwnerBits = 13;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PAINT = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_RELAX = 2'd3
  } req_t;

  localparam logic [0:0] CFG_FINEST = 1'b0;
  localparam logic [0:0] CFG_RATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PAINT,
    ST_OWN_RD,
    ST_OWN_WT,
    ST_SCAN,
    ST_MAP_WT,
    ST_VAL_WT,
    ST_DIV,
    ST_FACE_END,
    ST_MUL,
    ST_FINISH,
    ST_OUT
  } state_t;
endpackage

FILE: design/amr_if.sv
interface amr_in_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [5:0] cell_col;
  logic [5:0] cell_row;
  logic [2:0] cell_level;
  logic signed [15:0] value_in;
  modport source(output valid, req_type, cell_col, cell_row, cell_level, value_in,
                 input ready);
  modport sink(input valid, req_type, cell_col, cell_row, cell_level, value_in,
               output ready);
endinterface

interface amr_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] new_value;
  logic [7:0] neighbor_count;
  logic status;
  modport source(output valid, new_value, neighbor_count, status, input ready);
  modport sink(input valid, new_value, neighbor_count, status, output ready);
endinterface

FILE: design/amr_owner_map_face_relaxation_core.sv
// A clear empties every owner entry, a paint writes each owner entry of the cell, a write
// or a rejected request goes straight to its result, and a relax scans the four faces.
// Throughput: one item at a time; the next item is taken in the cycle its result is offered.
// The owner map and value store are single-port memories, one access a cycle each.
// Reset (synchronous, rst high): registers go to their defaults and every owner
// entry is marked empty through a clearing pass over all 4096 entries; values clear likewise.
`include "assert_macros.svh"
module amr_owner_map_face_relaxation_core (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [15:0] cfg_data,
  amr_in_if.sink in_ch,
  amr_out_if.source out_ch
);
  // Memories: owner map holds a valid bit plus owner index, values are signed.
  logic [amr_pkg::OwnerBits-1:0] own_mem [amr_pkg::GridN*amr_pkg::GridN];
  logic [15:0] val_mem [amr_pkg::GridN*amr_pkg::GridN];
  logic [amr_pkg::OwnerBits-1:0] own_q;
  logic signed [15:0] val_q;
  logic own_we, val_we;
  logic [11:0] own_addr, val_addr;
  logic [amr_pkg::OwnerBits-1:0] own_wd;
  logic signed [15:0] val_wd;

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_addr] <= own_wd;
    own_q <= own_mem[own_addr];
  end
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_addr] <= val_wd;
    val_q <= val_mem[val_addr];
  end

  // Registers.
  amr_pkg::state_t state, state_next;
  logic [2:0] finest_level;
  logic [15:0] relax_rate;
  logic [5:0] col, row;
  logic [6:0] w;
  logic [11:0] self;
  logic signed [15:0] own;
  logic [12:0] cnt;            // clear / sweep counter
  logic [6:0] si, sj;          // paint row/col offsets, scan position
  logic [1:0] face;
  logic [11:0] seen [amr_pkg::GridN];
  logic [11:0] seen_q;         // owner already found, read one step ahead
  logic [6:0] n;               // distinct owners in current face
  logic [6:0] k;               // duplicate search index
  logic [11:0] cand;
  logic dup;
  logic signed [22:0] fsum;
  logic signed [19:0] total;
  logic [8:0] tally;
  logic signed [16:0] quo;
  logic [24:0] rem;            // restoring divider remainder
  logic [23:0] dnum;
  logic [4:0] dstep;
  logic dneg;
  logic signed [37:0] prod;
  logic signed [15:0] res_v;
  logic res_st;
  logic [7:0] res_cnt;
  logic init;                  // reset clearing pass pending
  logic out_valid;
  logic signed [15:0] out_v;
  logic [7:0] out_cnt;
  logic out_st;

  // Combinational helpers.
  logic [7:0] w_c;
  logic lvl_ok, sq_ok;
  always_comb begin
    lvl_ok = in_ch.cell_level <= finest_level;
    w_c = 8'd1 << (finest_level - in_ch.cell_level);
    sq_ok = lvl_ok && ({2'b0, in_ch.cell_col} + w_c <= 8'd64)
            && ({2'b0, in_ch.cell_row} + w_c <= 8'd64);
  end

  // Scan position for face and step.
  logic signed [7:0] pc, pr;
  logic p_ok;
  always_comb begin
    case (face)
      2'd0: begin
        pc = $signed({2'b0, col}) - 8'sd1;
        pr = $signed({2'b0, row}) + $signed({1'b0, sj});
      end
      2'd1: begin
        pc = $signed({2'b0, col}) + $signed({1'b0, w});
        pr = $signed({2'b0, row}) + $signed({1'b0, sj});
      end
      2'd2: begin
        pc = $signed({2'b0, col}) + $signed({1'b0, sj});
        pr = $signed({2'b0, row}) - 8'sd1;
      end
      default: begin
        pc = $signed({2'b0, col}) + $signed({1'b0, sj});
        pr = $signed({2'b0, row}) + $signed({1'b0, w});
      end
    endcase
    p_ok = pc >= 0 && pc < 64 && pr >= 0 && pr < 64;
  end

  // Divider numerator 2*sum + n, signed; the divider takes its magnitude.
  logic signed [23:0] num_c;
  always_comb num_c = (24'(fsum) <<< 1) + 24'(signed'({1'b0, n}));

  logic [8:0] t4;
  always_comb t4 = tally;

  // Final rounding and saturation.
  logic signed [21:0] diffv;
  logic signed [37:0] adj;
  logic signed [21:0] resw;
  logic signed [15:0] res_sat;
  always_comb begin
    diffv = 22'(total) - (22'(own) <<< 2);
    adj = (prod + 38'sd131072) >>> 18;
    resw = 22'(own) + 22'(adj);
    res_sat = (resw > 22'sd32767) ? 16'sh7FFF :
              (resw < -22'sd32768) ? 16'sh8000 : resw[15:0];
  end

  always_comb begin
    state_next = state;
    own_we = 1'b0; val_we = 1'b0;
    own_addr = 12'(cnt); val_addr = 12'(cnt);
    own_wd = '0; val_wd = '0;
    in_ch.ready = 1'b0;
    case (state)
      amr_pkg::ST_IDLE: begin
        in_ch.ready = ~init;
        if (init) begin
          own_we = 1'b1; val_we = 1'b1;
          own_addr = cnt[11:0]; val_addr = cnt[11:0];
        end
      end
      amr_pkg::ST_CLEAR: begin
        own_we = 1'b1; own_addr = cnt[11:0];
        if (cnt[11:0] == 12'hFFF) state_next = amr_pkg::ST_OUT;
      end
      amr_pkg::ST_PAINT: begin
        own_we = 1'b1;
        own_addr = {6'(row + 6'(si)), 6'(col + 6'(sj))};
        own_wd = {1'b1, self};
        if (sj == w - 7'd1 && si == w - 7'd1) state_next = amr_pkg::ST_OUT;
      end
      amr_pkg::ST_OWN_RD: begin
        val_addr = self;
        state_next = amr_pkg::ST_OWN_WT;
      end
      amr_pkg::ST_OWN_WT: state_next = amr_pkg::ST_SCAN;
      amr_pkg::ST_SCAN: begin
        own_addr = {pr[5:0], pc[5:0]};
        if (sj == w) state_next = amr_pkg::ST_DIV;
        else if (p_ok) state_next = amr_pkg::ST_MAP_WT;
      end
      amr_pkg::ST_MAP_WT: begin
        own_addr = {pr[5:0], pc[5:0]};
        val_addr = (k == 7'd0) ? own_q[11:0] : cand;
        if (k == n) state_next = amr_pkg::ST_VAL_WT;
      end
      amr_pkg::ST_VAL_WT: state_next = amr_pkg::ST_SCAN;
      amr_pkg::ST_DIV: if (n == 0 || dstep == 5'd24) state_next = amr_pkg::ST_FACE_END;
      amr_pkg::ST_FACE_END: begin
        if (face == 2'd3) state_next = amr_pkg::ST_MUL;
        else state_next = amr_pkg::ST_SCAN;
      end
      amr_pkg::ST_MUL: state_next = amr_pkg::ST_FINISH;
      amr_pkg::ST_FINISH: begin
        val_we = 1'b1; val_addr = self; val_wd = res_sat;
        state_next = amr_pkg::ST_OUT;
      end
      amr_pkg::ST_OUT: begin
        if (!out_valid || out_ch.ready) state_next = amr_pkg::ST_IDLE;
      end
      default: state_next = amr_pkg::ST_IDLE;
    endcase
    if (state == amr_pkg::ST_IDLE && !init && in_ch.valid) begin
      case (amr_pkg::req_t'(in_ch.req_type))
        amr_pkg::REQ_CLEAR: state_next = amr_pkg::ST_CLEAR;
        amr_pkg::REQ_PAINT: state_next = sq_ok ? amr_pkg::ST_PAINT : amr_pkg::ST_OUT;
        amr_pkg::REQ_WRITE: begin
          val_we = 1'b1; val_addr = {in_ch.cell_row, in_ch.cell_col};
          val_wd = in_ch.value_in;
          state_next = amr_pkg::ST_OUT;
        end
        default: state_next = sq_ok ? amr_pkg::ST_OWN_RD : amr_pkg::ST_OUT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= amr_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Output register: a finished result waits here so the core can take the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == amr_pkg::ST_OUT && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
      out_v <= res_v; out_cnt <= res_cnt; out_st <= res_st;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.new_value = out_v;
  assign out_ch.neighbor_count = out_cnt;
  assign out_ch.status = out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      finest_level <= 3'd3; relax_rate <= 16'd1311;
      init <= 1'b1; cnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          amr_pkg::CFG_FINEST: finest_level <= cfg_data[2:0];
          amr_pkg::CFG_RATE: relax_rate <= cfg_data;
          default: ;
        endcase
      end
      if (init) begin
        if (cnt[11:0] == 12'hFFF) begin init <= 1'b0; cnt <= '0; end
        else cnt <= cnt + 13'd1;
      end
      case (state)
        amr_pkg::ST_IDLE: if (!init && in_ch.valid) begin
          col <= in_ch.cell_col; row <= in_ch.cell_row;
          w <= w_c[6:0]; self <= {in_ch.cell_row, in_ch.cell_col};
          si <= '0; sj <= '0; cnt <= '0; face <= '0; n <= '0; fsum <= '0;
          total <= '0; tally <= '0;
          res_v <= '0; res_cnt <= '0;
          res_st <= (in_ch.req_type == amr_pkg::REQ_PAINT
                     || in_ch.req_type == amr_pkg::REQ_RELAX) ? ~sq_ok : 1'b0;
        end
        amr_pkg::ST_CLEAR: cnt <= cnt + 13'd1;
        amr_pkg::ST_PAINT: begin
          if (sj == w - 7'd1) begin sj <= '0; si <= si + 7'd1; end
          else sj <= sj + 7'd1;
        end
        amr_pkg::ST_OWN_WT: own <= val_q;
        amr_pkg::ST_SCAN: begin
          k <= '0; dup <= 1'b0;
          if (sj == w) begin
            dneg <= num_c < 0;
            dnum <= num_c < 0 ? 24'(-num_c) : 24'(num_c);
            rem <= '0; dstep <= '0; quo <= '0;
          end else if (!p_ok) sj <= sj + 7'd1;
        end
        amr_pkg::ST_MAP_WT: begin
          // own_q holds the owner from the first cycle of this state; each found
          // owner is read in the cycle before it is compared.
          if (k == 7'd0) cand <= own_q[11:0];
          else if (seen_q == cand) dup <= 1'b1;
          if (k < n) begin
            seen_q <= seen[k[5:0]];
            k <= k + 7'd1;
          end
        end
        amr_pkg::ST_VAL_WT: begin
          sj <= sj + 7'd1;
          if (own_q[12] && cand != self && !dup && n < 7'd64) begin
            seen[n[5:0]] <= cand; n <= n + 7'd1;
            fsum <= fsum + 23'(val_q);
          end
        end
        amr_pkg::ST_DIV: if (n != 0 && dstep != 5'd24) begin
          // Restoring division of |2*sum+n| by 2n, one bit a cycle.
          if ({rem[23:0], dnum[23]} >= {17'd0, n, 1'b0}) begin
            rem <= {rem[23:0], dnum[23]} - {17'd0, n, 1'b0};
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= {rem[23:0], dnum[23]};
            quo <= {quo[15:0], 1'b0};
          end
          dnum <= dnum << 1;
          dstep <= dstep + 5'd1;
        end
        amr_pkg::ST_FACE_END: begin
          if (n == 0) total <= total + 20'(own);
          else if (dneg) total <= total - 20'(quo) - ((rem != 0) ? 20'sd1 : 20'sd0);
          else total <= total + 20'(quo);
          tally <= tally + 9'(n);
          face <= face + 2'd1; sj <= '0; n <= '0; fsum <= '0;
        end
        amr_pkg::ST_MUL: prod <= 38'(diffv) * $signed({1'b0, relax_rate});
        amr_pkg::ST_FINISH: begin
          res_v <= res_sat;
          res_cnt <= (t4 > 9'd255) ? 8'd255 : t4[7:0];
        end
        default: ;
      endcase
    end
  end

  // The map scan never runs during the reset clearing pass.
  `AMR_ASSERT_IMP(a_no_scan_in_init, init, state == amr_pkg::ST_IDLE, "work during init")
  `AMR_ASSERT_IMP(a_no_take_in_init, init, !in_ch.ready, "item taken during init")
  `AMR_ASSERT_NXT(a_out_after_finish, state == amr_pkg::ST_FINISH, state == amr_pkg::ST_OUT, "no result")
  `AMR_ASSERT_NXT(a_out_hold, out_valid && !out_ch.ready, out_valid, "result dropped")
endmodule

FILE: bench/amr_owner_map_face_relaxation_core_tb.sv
`timescale 1ns / 100ps

module amr_owner_map_face_relaxation_core_tb;

  // One expected result of the block.
  typedef struct packed {
    logic signed [15:0] new_value;
    logic [7:0] neighbor_count;
    logic status;
  } relax_result_t;

  // Keeps the model of the owner map and the cell values and checks results in order.
  class relax_scoreboard;
    int unsigned finest;
    int unsigned rate;
    bit owned[amr_pkg::GridN*amr_pkg::GridN];
    int unsigned owner[amr_pkg::GridN*amr_pkg::GridN];
    longint values[amr_pkg::GridN*amr_pkg::GridN];
    relax_result_t pending[$];
    int errors;
    int checked;
    int rejected;
    int relaxed;

    function new();
      finest = 3;
      rate = 1311;
      errors = 0;
      checked = 0;
      rejected = 0;
      relaxed = 0;
      foreach (owned[i]) begin
        owned[i] = 0;
        owner[i] = 0;
        values[i] = 0;
      end
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint clip(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Mean of the distinct owners just outside one face of the cell.
    function longint face_mean(int unsigned self, int col, int row, int w, int face,
                               longint own, output int unsigned found);
      int unsigned seen[$];
      longint sum;
      int c;
      int r;
      int unsigned k;
      int unsigned q;
      sum = 0;
      for (int s = 0; s < w; s++) begin
        case (face)
          0: begin c = col - 1; r = row + s; end
          1: begin c = col + w; r = row + s; end
          2: begin c = col + s; r = row - 1; end
          default: begin c = col + s; r = row + w; end
        endcase
        if (c < 0 || c >= amr_pkg::GridN || r < 0 || r >= amr_pkg::GridN) continue;
        k = r * amr_pkg::GridN + c;
        if (!owned[k]) continue;
        q = owner[k];
        if (q == self) continue;
        if (q inside {seen}) continue;
        seen.insert(seen.size(), q);
        sum += values[q];
      end
      found = seen.size();
      if (found == 0) return own;
      return floor_div(2 * sum + found, 2 * found);
    endfunction

    function void configure(logic [0:0] index, logic [15:0] data);
      if (index == amr_pkg::CFG_FINEST) finest = data[2:0];
      else rate = data;
    endfunction

    // Works out the result of an accepted item and applies it to the model.
    function void note_item(amr_pkg::req_t req, int col, int row, int lvl,
                            logic signed [15:0] vin);
      relax_result_t res;
      int w;
      bit fits;
      int unsigned self;
      longint own;
      longint total;
      longint nv;
      int unsigned tally;
      int unsigned f;
      res = '0;
      w = 0;
      fits = 0;
      self = row * amr_pkg::GridN + col;
      if (lvl <= finest) begin
        w = 1 << (finest - lvl);
        fits = (col + w <= amr_pkg::GridN) && (row + w <= amr_pkg::GridN);
      end
      case (req)
        amr_pkg::REQ_CLEAR: foreach (owned[i]) owned[i] = 0;
        amr_pkg::REQ_PAINT: begin
          if (!fits) res.status = 1;
          else
            for (int r = row; r < row + w; r++)
              for (int c = col; c < col + w; c++) begin
                owned[r*amr_pkg::GridN+c] = 1;
                owner[r*amr_pkg::GridN+c] = self;
              end
        end
        amr_pkg::REQ_WRITE: values[self] = vin;
        default: begin
          if (!fits) res.status = 1;
          else begin
            own = values[self];
            total = 0;
            tally = 0;
            for (int fc = 0; fc < 4; fc++) begin
              total += face_mean(self, col, row, w, fc, own, f);
              tally += f;
            end
            nv = clip(own + floor_div((total - 4 * own) * longint'(rate) + (longint'(1) << 17),
                                      longint'(1) << 18));
            values[self] = nv;
            res.new_value = nv;
            res.neighbor_count = (tally > 255) ? 255 : tally;
            relaxed++;
          end
        end
      endcase
      if (res.status) rejected++;
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(relax_result_t got);
      relax_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d count=%0d status=%0d", $time,
                 got.new_value, got.neighbor_count, got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.new_value !== exp.new_value) begin
        $display("%0t: new_value expected %0d actual %0d", $time, exp.new_value,
                 got.new_value);
        errors++;
      end
      if (got.neighbor_count !== exp.neighbor_count) begin
        $display("%0t: neighbor_count expected %0d actual %0d", $time,
                 exp.neighbor_count, got.neighbor_count);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  amr_in_if in_ch ();
  amr_out_if out_ch ();

  amr_owner_map_face_relaxation_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  relax_scoreboard board = new();
  bit hold_off = 0;
  int long_stall_done = 0;

  // Clock.
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Result side: checks each accepted item and stalls on its own pattern.
  initial begin
    int cyc;
    int unsigned hold;
    cyc = 0;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        board.check_result({out_ch.new_value, out_ch.neighbor_count, out_ch.status});
      cyc++;
      if (hold_off) begin
        for (hold = 0; hold < 3000; hold++) begin
          out_ch.ready <= 0;
          @(posedge clk);
        end
        hold_off = 0;
        long_stall_done = 1;
        cyc = 0;
      end
      if ((cyc / 300) % 3 == 2) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Hands one item to the block and notes it once accepted.
  task automatic send_item(amr_pkg::req_t req, int col, int row, int lvl,
                           logic signed [15:0] vin);
    in_ch.valid <= 1;
    in_ch.req_type <= req;
    in_ch.cell_col <= col;
    in_ch.cell_row <= row;
    in_ch.cell_level <= lvl;
    in_ch.value_in <= vin;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(req, col, row, lvl, vin);
  endtask

  // Drops valid for a random gap, sometimes none.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until every expected item has come back, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] index, logic [15:0] data);
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    board.configure(index, data);
    @(posedge clk);
  endtask

  // Random cell, usually aligned to its width, mostly small cells in range.
  task automatic random_item();
    int lvl;
    int w;
    int col;
    int row;
    int pick;
    amr_pkg::req_t req;
    pick = $urandom_range(0, 99);
    if (pick < 2) req = amr_pkg::REQ_CLEAR;
    else if (pick < 35) req = amr_pkg::REQ_PAINT;
    else if (pick < 60) req = amr_pkg::REQ_WRITE;
    else req = amr_pkg::REQ_RELAX;
    if ($urandom_range(0, 9) == 0) lvl = $urandom_range(0, 7);
    else lvl = board.finest - $urandom_range(0, board.finest > 2 ? 2 : board.finest);
    w = (lvl <= board.finest) ? (1 << (board.finest - lvl)) : 1;
    col = $urandom_range(0, 63);
    row = $urandom_range(0, 63);
    if ($urandom_range(0, 9) != 0) begin
      col = (col / w) * w;
      row = (row / w) * w;
    end
    send_item(req, col, row, lvl, $urandom_range(0, 65535));
  endtask

  // Stimulus.
  initial begin
    int burst;
    int sent;
    int phase_rates[4] = '{0, 65535, 1311, 40000};
    int phase_finest[4] = '{6, 0, 3, 4};
    rst = 1;
    cfg_we = 0;
    cfg_index = amr_pkg::CFG_FINEST;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.req_type = amr_pkg::REQ_CLEAR;
    in_ch.cell_col = 0;
    in_ch.cell_row = 0;
    in_ch.cell_level = 0;
    in_ch.value_in = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every request, rejected levels and squares.
    send_item(amr_pkg::REQ_WRITE, 0, 0, 0, 16'sh7FFF);
    send_item(amr_pkg::REQ_WRITE, 63, 63, 7, 16'sh8000);
    send_item(amr_pkg::REQ_WRITE, 8, 0, 0, 16'sh2000);
    send_item(amr_pkg::REQ_WRITE, 0, 8, 0, 16'shC000);
    send_item(amr_pkg::REQ_PAINT, 0, 0, 3, 0);
    send_item(amr_pkg::REQ_PAINT, 8, 0, 0, 0);
    send_item(amr_pkg::REQ_PAINT, 0, 8, 0, 0);
    send_item(amr_pkg::REQ_RELAX, 0, 0, 0, 0);
    send_item(amr_pkg::REQ_RELAX, 0, 0, 3, 0);
    send_item(amr_pkg::REQ_PAINT, 60, 60, 0, 0);
    send_item(amr_pkg::REQ_PAINT, 0, 0, 4, 0);
    send_item(amr_pkg::REQ_RELAX, 63, 63, 7, 0);
    send_item(amr_pkg::REQ_RELAX, 56, 56, 0, 0);
    send_item(amr_pkg::REQ_RELAX, 63, 63, 3, 16'sh5555);
    send_item(amr_pkg::REQ_CLEAR, 63, 63, 7, 16'shFFFF);
    send_item(amr_pkg::REQ_RELAX, 8, 0, 0, 0);
    drain();

    // Random phases through several register settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(amr_pkg::CFG_FINEST, phase_finest[ph]);
      write_reg(amr_pkg::CFG_RATE, phase_rates[ph]);
      sent = 0;
      while (sent < 500) begin
        burst = $urandom_range(1, 40);
        for (int i = 0; i < burst; i++) begin
          if (ph == 1 && sent == 100 && !long_stall_done) hold_off = 1;
          random_item();
          sent++;
        end
        idle_gap();
      end
      drain();
    end

    $display("Covered %0d results: %0d relaxations, %0d rejections, four gain settings.",
             board.checked, board.relaxed, board.rejected);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS amr_owner_map_face_relaxation_core");
    else
      $display("FAIL amr_owner_map_face_relaxation_core");
    $finish;
  end

  // Time limit.
  initial begin
    #400ms;
    $display("FAIL amr_owner_map_face_relaxation_core");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/amr_pkg.sv
design/amr_if.sv
design/amr_owner_map_face_relaxation_core.sv
bench/amr_owner_map_face_relaxation_core_tb.sv
